### hdl/qlsf_pkg.sv
// Package: widths, operand codes and the Cramer term schedule of the quadratic fit.
`default_nettype none
package qlsf_pkg;

	localparam int COORD_BITS = 10;
	localparam int MAX_POINTS = 4096;
	localparam int FRAC_BITS  = 24;

	// Fixed port field widths
	localparam int IN_COORD_W = 10;
	localparam int COEF_W     = 48;
	localparam int PTS_W      = 13;

	// Internal widths
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int S1_W   = COORD_BITS + CNT_W;
	localparam int S2_W   = 2 * COORD_BITS + CNT_W;
	localparam int S3_W   = 3 * COORD_BITS + CNT_W;
	localparam int S4_W   = 4 * COORD_BITS + CNT_W;
	localparam int SUM_W  = S4_W;
	localparam int PROD_W = 3 * SUM_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int NUM_W  = ACC_W - 1 + FRAC_BITS;
	localparam int STEP_W = $clog2(NUM_W);

	// Operand select codes
	localparam logic [2:0] OP_N  = 3'd0;
	localparam logic [2:0] OP_S1 = 3'd1;
	localparam logic [2:0] OP_S2 = 3'd2;
	localparam logic [2:0] OP_S3 = 3'd3;
	localparam logic [2:0] OP_S4 = 3'd4;
	localparam logic [2:0] OP_T0 = 3'd5;
	localparam logic [2:0] OP_T1 = 3'd6;
	localparam logic [2:0] OP_T2 = 3'd7;

	// Term groups: determinant, then one per coefficient
	localparam logic [1:0] GRP_DET   = 2'd0;
	localparam logic [1:0] GRP_CONST = 2'd1;
	localparam logic [1:0] GRP_LIN   = 2'd2;
	localparam logic [1:0] GRP_QUAD  = 2'd3;

	localparam int NUM_TERMS = 24;
	localparam int TERM_W    = $clog2(NUM_TERMS);

	typedef struct packed {
		logic       neg;
		logic [2:0] a;
		logic [2:0] b;
		logic [2:0] c;
		logic       grp_end;
		logic [1:0] grp;
	} term_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              acc_clr;
		logic              mul_load1;
		logic              mul_load2;
		logic              mul_step;
		logic              acc_add;
		logic              det_latch;
		logic              div_load;
		logic              div_step;
		logic              coef_store;
		logic              load_out;
		logic              sums_clr;
		logic [TERM_W-1:0] term;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic busy;
		logic acc_zero;
	} stat_t;

	function automatic term_t mk(input logic neg, input logic [2:0] a, input logic [2:0] b,
			input logic [2:0] c, input logic ge, input logic [1:0] g);
		term_t t;
		t.neg = neg; t.a = a; t.b = b; t.c = c; t.grp_end = ge; t.grp = g;
		return t;
	endfunction

	// Products of the 3x3 cofactor expansions, positive terms first
	function automatic term_t term_of(input logic [TERM_W-1:0] idx);
		term_t t;
		unique case (idx)
			5'd0:  t = mk(1'b0, OP_N,  OP_S2, OP_S4, 1'b0, GRP_DET);
			5'd1:  t = mk(1'b0, OP_S1, OP_S2, OP_S3, 1'b0, GRP_DET);
			5'd2:  t = mk(1'b0, OP_S1, OP_S2, OP_S3, 1'b0, GRP_DET);
			5'd3:  t = mk(1'b1, OP_N,  OP_S3, OP_S3, 1'b0, GRP_DET);
			5'd4:  t = mk(1'b1, OP_S1, OP_S1, OP_S4, 1'b0, GRP_DET);
			5'd5:  t = mk(1'b1, OP_S2, OP_S2, OP_S2, 1'b1, GRP_DET);
			5'd6:  t = mk(1'b0, OP_T0, OP_S2, OP_S4, 1'b0, GRP_CONST);
			5'd7:  t = mk(1'b0, OP_S1, OP_S3, OP_T2, 1'b0, GRP_CONST);
			5'd8:  t = mk(1'b0, OP_S2, OP_S3, OP_T1, 1'b0, GRP_CONST);
			5'd9:  t = mk(1'b1, OP_T0, OP_S3, OP_S3, 1'b0, GRP_CONST);
			5'd10: t = mk(1'b1, OP_S1, OP_S4, OP_T1, 1'b0, GRP_CONST);
			5'd11: t = mk(1'b1, OP_S2, OP_S2, OP_T2, 1'b1, GRP_CONST);
			5'd12: t = mk(1'b0, OP_N,  OP_T1, OP_S4, 1'b0, GRP_LIN);
			5'd13: t = mk(1'b0, OP_T0, OP_S2, OP_S3, 1'b0, GRP_LIN);
			5'd14: t = mk(1'b0, OP_S1, OP_S2, OP_T2, 1'b0, GRP_LIN);
			5'd15: t = mk(1'b1, OP_N,  OP_S3, OP_T2, 1'b0, GRP_LIN);
			5'd16: t = mk(1'b1, OP_T0, OP_S1, OP_S4, 1'b0, GRP_LIN);
			5'd17: t = mk(1'b1, OP_S2, OP_S2, OP_T1, 1'b1, GRP_LIN);
			5'd18: t = mk(1'b0, OP_N,  OP_S2, OP_T2, 1'b0, GRP_QUAD);
			5'd19: t = mk(1'b0, OP_S1, OP_S2, OP_T1, 1'b0, GRP_QUAD);
			5'd20: t = mk(1'b0, OP_T0, OP_S1, OP_S3, 1'b0, GRP_QUAD);
			5'd21: t = mk(1'b1, OP_N,  OP_S3, OP_T1, 1'b0, GRP_QUAD);
			5'd22: t = mk(1'b1, OP_S1, OP_S1, OP_T2, 1'b0, GRP_QUAD);
			5'd23: t = mk(1'b1, OP_T0, OP_S2, OP_S2, 1'b1, GRP_QUAD);
			default: t = mk(1'b0, OP_N, OP_N, OP_N, 1'b1, GRP_QUAD);
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

### hdl/qlsf_point_if.sv
// Interface: input point channel.
`default_nettype none
interface qlsf_point_if import qlsf_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [IN_COORD_W-1:0] row_coord;
	logic [IN_COORD_W-1:0] col_coord;
	logic                  last_point;

	modport source (output valid, row_coord, col_coord, last_point, input ready);
	modport sink   (input valid, row_coord, col_coord, last_point, output ready);
endinterface
`default_nettype wire

### hdl/qlsf_result_if.sv
// Interface: fit result channel.
`default_nettype none
interface qlsf_result_if import qlsf_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] coef_const;
	logic signed [COEF_W-1:0] coef_linear;
	logic signed [COEF_W-1:0] coef_quad;
	logic                     singular;
	logic [PTS_W-1:0]         points_used;

	modport source (output valid, coef_const, coef_linear, coef_quad, singular, points_used,
		input ready);
	modport sink   (input valid, coef_const, coef_linear, coef_quad, singular, points_used,
		output ready);
endinterface
`default_nettype wire

### hdl/qlsf_datapath.sv
// Datapath: point accumulators, serial multiplier, term accumulator, divider, result regs.
`default_nettype none
module qlsf_datapath import qlsf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     pt_accept,
	input  wire logic [IN_COORD_W-1:0]    row_coord,
	input  wire logic [IN_COORD_W-1:0]    col_coord,
	input  wire cmd_t                     cmd,
	output stat_t                         stat,
	output logic signed [COEF_W-1:0]      coef_const,
	output logic signed [COEF_W-1:0]      coef_linear,
	output logic signed [COEF_W-1:0]      coef_quad,
	output logic                          singular,
	output logic [PTS_W-1:0]              points_used
);

	// Point pipeline
	logic                    v_s1, v_s2, en_s1, en_s2;
	logic [COORD_BITS-1:0]   r_s1, c_s1, r_s2, c_s2;
	logic [2*COORD_BITS-1:0] r2_s2, cr_s2;
	logic [CNT_W-1:0]        count_q;
	logic [S1_W-1:0]         s1_q, t0_q;
	logic [S2_W-1:0]         s2_q, t1_q;
	logic [S3_W-1:0]         s3_q, t2_q;
	logic [S4_W-1:0]         s4_q;
	logic                    room;

	assign room = count_q < CNT_W'(MAX_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
			count_q <= '0;
		end else begin
			v_s1 <= pt_accept;
			v_s2 <= v_s1;
			en_s1 <= pt_accept && room;
			en_s2 <= en_s1;
			if (cmd.sums_clr) begin
				count_q <= '0;
			end else if (pt_accept && room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Stage 1 registers the coordinates, stage 2 squares; cubes and sums at accumulation
	always_ff @(posedge clk) begin
		r_s1 <= COORD_BITS'(row_coord);
		c_s1 <= COORD_BITS'(col_coord);
		r_s2 <= r_s1;
		c_s2 <= c_s1;
		r2_s2 <= (2*COORD_BITS)'(r_s1) * (2*COORD_BITS)'(r_s1);
		cr_s2 <= (2*COORD_BITS)'(c_s1) * (2*COORD_BITS)'(r_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
			t0_q <= '0; t1_q <= '0; t2_q <= '0;
		end else if (cmd.sums_clr) begin
			s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
			t0_q <= '0; t1_q <= '0; t2_q <= '0;
		end else if (en_s2) begin
			s1_q <= s1_q + S1_W'(r_s2);
			s2_q <= s2_q + S2_W'(r2_s2);
			s3_q <= s3_q + S3_W'(r2_s2) * S3_W'(r_s2);
			s4_q <= s4_q + S4_W'(r2_s2) * S4_W'(r2_s2);
			t0_q <= t0_q + S1_W'(c_s2);
			t1_q <= t1_q + S2_W'(cr_s2);
			t2_q <= t2_q + S3_W'(cr_s2) * S3_W'(r_s2);
		end
	end

	// Operand select for the current term
	term_t            t;
	logic [SUM_W-1:0] op_a, op_b, op_c;

	assign t = term_of(cmd.term);

	function automatic logic [SUM_W-1:0] pick(input logic [2:0] code,
			input logic [CNT_W-1:0] n, input logic [S1_W-1:0] a1, input logic [S2_W-1:0] a2,
			input logic [S3_W-1:0] a3, input logic [S4_W-1:0] a4, input logic [S1_W-1:0] b0,
			input logic [S2_W-1:0] b1, input logic [S3_W-1:0] b2);
		logic [SUM_W-1:0] v;
		unique case (code)
			OP_N:    v = SUM_W'(n);
			OP_S1:   v = SUM_W'(a1);
			OP_S2:   v = SUM_W'(a2);
			OP_S3:   v = SUM_W'(a3);
			OP_S4:   v = SUM_W'(a4);
			OP_T0:   v = SUM_W'(b0);
			OP_T1:   v = SUM_W'(b1);
			OP_T2:   v = SUM_W'(b2);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign op_a = pick(t.a, count_q, s1_q, s2_q, s3_q, s4_q, t0_q, t1_q, t2_q);
	assign op_b = pick(t.b, count_q, s1_q, s2_q, s3_q, s4_q, t0_q, t1_q, t2_q);
	assign op_c = pick(t.c, count_q, s1_q, s2_q, s3_q, s4_q, t0_q, t1_q, t2_q);

	// Shift-add multiplier, one multiplier bit per cycle
	logic [PROD_W-1:0] mcand_q, prod_q;
	logic [SUM_W-1:0]  mplier_q;
	logic              neg_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_load1) begin
			mcand_q <= PROD_W'(op_a);
			mplier_q <= op_b;
			prod_q <= '0;
			neg_q <= t.neg;
		end else if (cmd.mul_load2) begin
			mcand_q <= prod_q;
			mplier_q <= op_c;
			prod_q <= '0;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	// Signed term accumulator
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        acc_mag;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= neg_q ? acc_q - $signed({3'b000, prod_q}) : acc_q + $signed({3'b000, prod_q});
		end
	end

	assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign stat = '{busy: v_s1 | v_s2, acc_zero: acc_q == '0};

	// Determinant magnitude and sign
	logic [ACC_W-1:0] det_mag_q;
	logic             det_neg_q, det_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_zero_q <= 1'b0;
		end else if (cmd.det_latch) begin
			det_zero_q <= acc_q == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.det_latch) begin
			det_mag_q <= acc_mag;
			det_neg_q <= acc_q[ACC_W-1];
		end
	end

	// Restoring divider, one quotient bit per cycle
	logic [NUM_W-1:0] num_q, quo_q;
	logic [ACC_W-1:0] rem_q, rem_sh;
	logic             num_neg_q, q_bit;

	assign rem_sh = {rem_q[ACC_W-2:0], num_q[NUM_W-1]};
	assign q_bit = rem_sh >= det_mag_q;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= NUM_W'(acc_mag) << FRAC_BITS;
			rem_q <= '0;
			quo_q <= '0;
			num_neg_q <= acc_q[ACC_W-1];
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? rem_sh - det_mag_q : rem_sh;
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], q_bit};
		end
	end

	// Saturate and apply sign
	logic             res_neg;
	logic [NUM_W-1:0] limit, sat;
	logic [COEF_W-1:0] coef_val;

	assign res_neg = num_neg_q ^ det_neg_q;
	assign limit = res_neg ? (NUM_W'(1) << (COEF_W - 1))
		: ((NUM_W'(1) << (COEF_W - 1)) - NUM_W'(1));
	assign sat = (quo_q > limit) ? limit : quo_q;
	assign coef_val = res_neg ? COEF_W'(-sat) : COEF_W'(sat);

	logic [COEF_W-1:0] c0_q, c1_q, c2_q;

	always_ff @(posedge clk) begin
		if (cmd.det_latch) begin
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
		end else if (cmd.coef_store) begin
			unique case (t.grp)
				GRP_CONST: c0_q <= coef_val;
				GRP_LIN:   c1_q <= coef_val;
				GRP_QUAD:  c2_q <= coef_val;
				default:   c0_q <= c0_q;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			coef_const <= $signed(c0_q);
			coef_linear <= $signed(c1_q);
			coef_quad <= $signed(c2_q);
			singular <= det_zero_q;
			points_used <= PTS_W'(count_q);
		end
	end

`ifndef SYNTHESIS
	a_clr_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sums_clr |=> count_q == '0)
		else $error("point count not cleared after solve");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> !det_zero_q)
		else $error("division started on zero determinant");
`endif

endmodule
`default_nettype wire

### hdl/qlsf_ctrl.sv
// Controller: point acceptance and the solve sequencer.
`default_nettype none
module qlsf_ctrl import qlsf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_last,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DRAIN  = 4'd1;
	localparam logic [3:0] ST_LOAD1  = 4'd2;
	localparam logic [3:0] ST_MUL1   = 4'd3;
	localparam logic [3:0] ST_LOAD2  = 4'd4;
	localparam logic [3:0] ST_MUL2   = 4'd5;
	localparam logic [3:0] ST_ACC    = 4'd6;
	localparam logic [3:0] ST_DET    = 4'd7;
	localparam logic [3:0] ST_DIVLD  = 4'd8;
	localparam logic [3:0] ST_DIV    = 4'd9;
	localparam logic [3:0] ST_STORE  = 4'd10;
	localparam logic [3:0] ST_FINISH = 4'd11;

	logic [3:0]        state_q, state_d;
	logic [TERM_W-1:0] term_q, term_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q;
	term_t             t;
	term_t             t_prev;

	assign t = term_of(term_q);
	assign t_prev = term_of(term_q - TERM_W'(1));
	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		term_d = term_q;
		step_d = step_q;
		cmd = '0;
		cmd.term = term_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				term_d = '0;
				if (!stat.busy) begin
					state_d = ST_LOAD1;
				end
			end
			ST_LOAD1: begin
				cmd.mul_load1 = 1'b1;
				cmd.acc_clr = term_q == '0 || t_prev.grp_end;
				step_d = '0;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_step = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_LOAD2;
				end
			end
			ST_LOAD2: begin
				cmd.mul_load2 = 1'b1;
				step_d = '0;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_step = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				priority if (!t.grp_end) begin
					term_d = term_q + TERM_W'(1);
					state_d = ST_LOAD1;
				end else if (t.grp == GRP_DET) begin
					state_d = ST_DET;
				end else begin
					state_d = ST_DIVLD;
				end
			end
			ST_DET: begin
				cmd.det_latch = 1'b1;
				if (stat.acc_zero) begin
					state_d = ST_FINISH;
				end else begin
					term_d = term_q + TERM_W'(1);
					state_d = ST_LOAD1;
				end
			end
			ST_DIVLD: begin
				cmd.div_load = 1'b1;
				step_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.coef_store = 1'b1;
				if (term_q == TERM_W'(NUM_TERMS - 1)) begin
					state_d = ST_FINISH;
				end else begin
					term_d = term_q + TERM_W'(1);
					state_d = ST_LOAD1;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q) begin
					cmd.load_out = 1'b1;
					cmd.sums_clr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			term_q <= term_d;
			step_q <= step_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		term_q < TERM_W'(NUM_TERMS))
		else $error("term index out of range");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not raise valid");
`endif

endmodule
`default_nettype wire

### hdl/quadratic_least_squares_fit.sv
// Top level: quadratic least-squares fit over a stream of points.
// Points are taken one per cycle and folded into exact integer sums through a
// two-stage multiply pipeline. A point marked last starts the solve: the pipeline
// drains, then a shared shift-add multiplier forms 24 triple products of Cramer's
// rule, and a restoring divider produces each of the three coefficients. No points
// are taken during the solve. Coefficients are signed fixed point with FRAC_BITS
// fraction bits, truncated toward zero and saturated to 48 bits; a zero determinant
// gives singular set and zero coefficients. Points beyond MAX_POINTS are dropped,
// and the sums clear once the result is loaded. A new set of points may stream in
// while a result still waits to be taken.
`default_nettype none
module quadratic_least_squares_fit import qlsf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	qlsf_point_if.sink     points,
	qlsf_result_if.source  result
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;
	logic  out_valid;

	assign points.ready = in_ready;
	assign result.valid = out_valid;

	qlsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (points.valid),
		.in_last   (points.last_point),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	qlsf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.pt_accept   (points.valid & in_ready),
		.row_coord   (points.row_coord),
		.col_coord   (points.col_coord),
		.cmd         (cmd),
		.stat        (stat),
		.coef_const  (result.coef_const),
		.coef_linear (result.coef_linear),
		.coef_quad   (result.coef_quad),
		.singular    (result.singular),
		.points_used (result.points_used)
	);

endmodule
`default_nettype wire

### verif/tb_quadratic_least_squares_fit.sv
// Testbench: random and directed point sets for the quadratic least-squares fit.
`timescale 1ns / 100ps
module tb_quadratic_least_squares_fit;
	import qlsf_pkg::*;

	typedef logic [255:0] wide_t;

	typedef struct {
		logic [IN_COORD_W-1:0] row;
		logic [IN_COORD_W-1:0] col;
		logic                  last;
		logic                  drain;  // wait for all fits before this transfer
		logic                  hold;   // start the long receiver hold-off here
	} point_t;

	typedef struct {
		logic signed [COEF_W-1:0] c0;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
		logic                     sing;
		logic [PTS_W-1:0]         used;
	} fit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qlsf_point_if  pts();
	qlsf_result_if res();

	quadratic_least_squares_fit uut (.clk(clk), .arst_n(arst_n), .points(pts), .result(res));

	always #4 clk = ~clk;

	point_t point_q[$];
	fit_t   fit_q[$];
	int     errors = 0;
	int     hold_token = 0;
	longint cycles = 0;

	// Running normal-equation sums of the predictor and response
	logic [63:0] n_pts, s1, s2, s3, s4, t0, t1, t2;

	function automatic wide_t prod3(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		wide_t x;
		x = wide_t'(a);
		x = x * wide_t'(b);
		x = x * wide_t'(c);
		return x;
	endfunction

	// Cramer quotient: (pos-neg) * 2^FRAC_BITS / det, toward zero, saturated
	function automatic logic [COEF_W-1:0] cramer_coef(input wide_t pos, input wide_t neg,
			input wide_t det_mag, input logic det_neg);
		wide_t mag, q, lim;
		logic num_neg, res_neg;
		logic [COEF_W-1:0] v;
		num_neg = pos < neg;
		mag = num_neg ? neg - pos : pos - neg;
		mag = mag << FRAC_BITS;
		q = mag / det_mag;
		res_neg = num_neg != det_neg;
		lim = res_neg ? (wide_t'(1) << 47) : ((wide_t'(1) << 47) - 1);
		if (q > lim)
			q = lim;
		v = q[COEF_W-1:0];
		if (res_neg)
			v = -v;
		return v;
	endfunction

	function automatic void clear_sums();
		n_pts = 0; s1 = 0; s2 = 0; s3 = 0; s4 = 0; t0 = 0; t1 = 0; t2 = 0;
	endfunction

	// Fold one point into the sums; on a last point queue the expected fit
	function automatic void fit_point(input point_t p);
		logic [63:0] r, c;
		wide_t dp, dn, det;
		logic det_neg;
		fit_t f;
		r = 64'(p.row);
		c = 64'(p.col);
		if (n_pts < MAX_POINTS) begin
			n_pts += 1;
			s1 += r; s2 += r * r; s3 += r * r * r; s4 += r * r * r * r;
			t0 += c; t1 += c * r; t2 += c * r * r;
		end
		if (!p.last)
			return;
		dp = prod3(n_pts, s2, s4) + 2 * prod3(s1, s2, s3);
		dn = prod3(n_pts, s3, s3) + prod3(s1, s1, s4) + prod3(s2, s2, s2);
		det_neg = dp < dn;
		det = det_neg ? dn - dp : dp - dn;
		f.used = n_pts[PTS_W-1:0];
		f.sing = det == 0;
		if (f.sing) begin
			f.c0 = 0; f.c1 = 0; f.c2 = 0;
		end else begin
			f.c0 = cramer_coef(
				prod3(t0, s2, s4) + prod3(s1, s3, t2) + prod3(s2, s3, t1),
				prod3(t0, s3, s3) + prod3(s1, s4, t1) + prod3(s2, s2, t2), det, det_neg);
			f.c1 = cramer_coef(
				prod3(n_pts, t1, s4) + prod3(t0, s2, s3) + prod3(s1, s2, t2),
				prod3(n_pts, s3, t2) + prod3(t0, s1, s4) + prod3(s2, s2, t1), det, det_neg);
			f.c2 = cramer_coef(
				prod3(n_pts, s2, t2) + prod3(s1, s2, t1) + prod3(t0, s1, s3),
				prod3(n_pts, s3, t1) + prod3(s1, s1, t2) + prod3(t0, s2, s2), det, det_neg);
		end
		fit_q.insert(fit_q.size(), f);
		clear_sums();
	endfunction

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 19);
		if (k < 12)
			return 0;
		if (k < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void add_point(input int r, input int c, input logic last);
		point_t p;
		p.row = IN_COORD_W'(r); p.col = IN_COORD_W'(c); p.last = last;
		p.drain = 1'b0; p.hold = 1'b0;
		point_q.insert(point_q.size(), p);
	endfunction

	// Driver
	point_t cur;
	int     send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts.valid <= 1'b0;
			pts.row_coord <= '0;
			pts.col_coord <= '0;
			pts.last_point <= 1'b0;
			send_gap = 0;
			clear_sums();
		end else begin
			if (pts.valid && pts.ready)
				fit_point(cur);
			if (!pts.valid || pts.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pts.valid <= 1'b0;
				end else if (point_q.size() == 0 ||
						(point_q[0].drain && fit_q.size() != 0)) begin
					pts.valid <= 1'b0;
				end else begin
					cur = point_q.pop_front();
					if (cur.hold)
						hold_token++;
					pts.valid <= 1'b1;
					pts.row_coord <= cur.row;
					pts.col_coord <= cur.col;
					pts.last_point <= cur.last;
					send_gap = pick_gap();
				end
			end
		end
	end

	// Monitor and checker
	fit_t got, want;
	int   stall, hold_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall = 0;
			hold_seen = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.c0 = res.coef_const; got.c1 = res.coef_linear; got.c2 = res.coef_quad;
				got.sing = res.singular; got.used = res.points_used;
				if (fit_q.size() == 0) begin
					$error("fit result with none expected");
					errors++;
				end else begin
					want = fit_q.pop_front();
					if (got.c0 !== want.c0) begin
						$error("coef_const: expected %0d, got %0d", want.c0, got.c0);
						errors++;
					end
					if (got.c1 !== want.c1) begin
						$error("coef_linear: expected %0d, got %0d", want.c1, got.c1);
						errors++;
					end
					if (got.c2 !== want.c2) begin
						$error("coef_quad: expected %0d, got %0d", want.c2, got.c2);
						errors++;
					end
					if (got.sing !== want.sing) begin
						$error("singular: expected %0d, got %0d", want.sing, got.sing);
						errors++;
					end
					if (got.used !== want.used) begin
						$error("points_used: expected %0d, got %0d", want.used, got.used);
						errors++;
					end
				end
			end
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				stall = 9000;
			end
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				res.ready <= (stall == 0);
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus
	int len, mode, base, npts;
	initial begin
		// Directed sets: singular sizes, extremes, constant rows
		add_point(0, 0, 1'b1);
		add_point(1023, 1023, 1'b0); add_point(0, 0, 1'b1);
		add_point(0, 1023, 1'b0); add_point(512, 0, 1'b0); add_point(1023, 1023, 1'b1);
		add_point(0, 1023, 1'b0); add_point(1, 0, 1'b0); add_point(2, 1023, 1'b1);
		add_point(1023, 0, 1'b0); add_point(1022, 1023, 1'b0); add_point(1021, 0, 1'b1);
		add_point(700, 5, 1'b0); add_point(700, 900, 1'b0); add_point(700, 17, 1'b1);
		add_point(341, 682, 1'b0); add_point(682, 341, 1'b0); add_point(341, 0, 1'b0);
		add_point(682, 1023, 1'b1);
		// Full accumulator: points past the limit are dropped
		for (int i = 0; i < MAX_POINTS + 5; i++)
			add_point($urandom_range(0, 1023), $urandom_range(0, 1023),
				i == MAX_POINTS + 4);
		// Random sets
		npts = 0;
		for (int s = 0; npts < 830; s++) begin
			len = $urandom_range(1, 20);
			mode = $urandom_range(0, 9);
			base = $urandom_range(0, 1023);
			for (int i = 0; i < len; i++) begin
				if (mode == 0)
					add_point(base, $urandom_range(0, 1023), i == len - 1);
				else if (mode == 1)
					add_point((base + i % 2) % 1024, $urandom_range(0, 1023), i == len - 1);
				else if (mode == 2)
					add_point($urandom_range(0, 1) * 1023, $urandom_range(0, 1) * 1023,
						i == len - 1);
				else
					add_point($urandom_range(0, 1023), $urandom_range(0, 1023),
						i == len - 1);
				if (i == 0 && s == 10)
					point_q[$].drain = 1'b1;
				if (i == 0 && s == 20)
					point_q[$].hold = 1'b1;
			end
			npts += len;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (point_q.size() == 0 && !pts.valid && fit_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

### quadratic_least_squares_fit.f
hdl/qlsf_pkg.sv
hdl/qlsf_point_if.sv
hdl/qlsf_result_if.sv
hdl/qlsf_datapath.sv
hdl/qlsf_ctrl.sv
hdl/quadratic_least_squares_fit.sv
verif/tb_quadratic_least_squares_fit.sv
